/* src/csbr_pkg.sv */
package csbr_pkg;

    localparam int COLUMN_COUNT     = 32;
    localparam int SLOTS_PER_COLUMN = 20;
    localparam int SURFACE_COLUMNS  = 8;
    localparam int STORE_DEPTH      = COLUMN_COUNT * SLOTS_PER_COLUMN;
    localparam int STORE_AW         = $clog2(STORE_DEPTH);
    localparam int COL_W            = $clog2(COLUMN_COUNT);
    localparam int SURF_W           = $clog2(SURFACE_COLUMNS);
    localparam int SLOT_W           = 5;
    localparam int SUB_W            = 3;
    localparam int QUEUE_DEPTH      = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_TOP_ROW = 3'd0;

    localparam logic [1:0] ACT_SURFACE = 2'd0;
    localparam logic [1:0] ACT_INIT    = 2'd1;
    localparam logic [1:0] ACT_LOAD    = 2'd2;

    localparam logic [7:0] ST_COL_BASE = 8'd176;
    localparam logic [7:0] ST_COL_LAST = 8'd183;
    localparam logic [7:0] ST_SET      = 8'd191;
    localparam logic [6:0] CC_SET_BASE = 7'd90;
    localparam logic [6:0] CC_SET_LAST = 7'd93;
    localparam logic [6:0] CC_UP       = 7'd108;
    localparam logic [6:0] CC_DOWN     = 7'd109;
    localparam logic [6:0] LED_ON      = 7'd127;
    localparam logic [6:0] LED_OFF     = 7'd0;

    localparam logic [6:0] KNOB_CC [4] = '{7'd102, 7'd105, 7'd106, 7'd107};

    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        status_byte;
        logic [6:0]        data1;
        logic [6:0]        data2;
        logic [COL_W-1:0]  load_column;
        logic [SLOT_W-1:0] load_slot;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        midi_status;
        logic [6:0]        midi_data1;
        logic [6:0]        midi_data2;
        logic [COL_W-1:0]  event_column;
        logic [SLOT_W-1:0] event_slot;
        logic [6:0]        event_value;
        logic              last;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_INIT,
        OP_LOAD,
        OP_SET_SELECT,
        OP_SET_LEDS,
        OP_BUTTON,
        OP_KNOB
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [SURF_W-1:0] surf_col;
        logic [1:0]        sel;
        logic              pressed;
        logic [6:0]        value;
        logic [COL_W-1:0]  load_col;
        logic [SLOT_W-1:0] load_slot;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_START,
        B_FETCH,
        B_SHOW
    } back_state_t;

    typedef enum logic [1:0] {
        PH_SET_PRE,
        PH_COLS,
        PH_SET_POST,
        PH_EVENT
    } phase_t;

    function automatic logic [STORE_AW-1:0] store_addr(input logic [COL_W-1:0] col,
                                                       input logic [SLOT_W-1:0] slot);
        return STORE_AW'(col) * STORE_AW'(SLOTS_PER_COLUMN) + STORE_AW'(slot);
    endfunction

endpackage

/* src/csbr_front.sv */
module csbr_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  csbr_pkg::in_item_t    s_item,
    input  csbr_pkg::back_status_t status,
    output logic                  push_valid,
    input  logic                  push_ready,
    output csbr_pkg::cmd_t        push_item
);
    import csbr_pkg::*;

    logic       keep;
    logic       is_knob;
    logic [1:0] knob_idx;
    logic [6:0] set_off;

    assign set_off = s_item.data1 - CC_SET_BASE;

    always_comb begin
        is_knob  = 1'b0;
        knob_idx = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (s_item.data1 == KNOB_CC[i]) begin
                is_knob  = 1'b1;
                knob_idx = 2'(i);
            end
        end
    end

    always_comb begin
        keep                = 1'b0;
        push_item.op        = OP_INIT;
        push_item.surf_col  = s_item.status_byte[SURF_W-1:0];
        push_item.sel       = 2'd0;
        push_item.pressed   = (s_item.data2 == 7'd0);
        push_item.value     = s_item.data2;
        push_item.load_col  = s_item.load_column;
        push_item.load_slot = s_item.load_slot;
        case (s_item.action)
            ACT_INIT: begin
                keep         = 1'b1;
                push_item.op = OP_INIT;
            end
            ACT_LOAD: begin
                keep         = (s_item.load_slot < SLOT_W'(SLOTS_PER_COLUMN));
                push_item.op = OP_LOAD;
            end
            ACT_SURFACE: begin
                if (s_item.status_byte == ST_SET &&
                    s_item.data1 inside {[CC_SET_BASE:CC_SET_LAST]}) begin
                    keep          = 1'b1;
                    push_item.sel = set_off[1:0];
                    push_item.op  = (s_item.data2 != 7'd0) ? OP_SET_SELECT : OP_SET_LEDS;
                end else if (s_item.status_byte inside {[ST_COL_BASE:ST_COL_LAST]}) begin
                    if (s_item.data1 == CC_UP || s_item.data1 == CC_DOWN) begin
                        keep          = 1'b1;
                        push_item.op  = OP_BUTTON;
                        push_item.sel = {1'b0, s_item.data1 == CC_DOWN};
                    end else if (is_knob) begin
                        keep          = 1'b1;
                        push_item.op  = OP_KNOB;
                        push_item.sel = knob_idx;
                    end
                end
            end
            default: keep = 1'b0;
        endcase
    end

    assign s_ready    = push_ready && !status.clearing;
    assign push_valid = s_valid && s_ready && keep;

endmodule

/* src/csbr_queue.sv */
module csbr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  csbr_pkg::cmd_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output csbr_pkg::cmd_t pop_item
);
    import csbr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/csbr_back.sv */
module csbr_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             top_row,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  csbr_pkg::cmd_t         pop_item,
    output csbr_pkg::back_status_t status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output csbr_pkg::out_item_t    m_item
);
    import csbr_pkg::*;

    back_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    cmd_t        cmd_reg, cmd_next;
    logic [SURF_W-1:0] col_cnt_reg, col_cnt_next;
    logic [SURF_W-1:0] col_last_reg, col_last_next;
    logic [SUB_W-1:0]  sub_cnt_reg, sub_cnt_next;
    logic [SUB_W-1:0]  sub_last_reg, sub_last_next;
    logic              knobs_first_reg, knobs_first_next;
    logic              set_post_reg, set_post_next;
    logic [1:0]        set_reg, set_next;
    logic [COLUMN_COUNT-1:0][1:0] mode_reg, mode_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [STORE_AW-1:0] clear_cnt_reg, clear_cnt_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;

    logic [6:0]          store_mem [STORE_DEPTH];
    logic [6:0]          rdata_reg;
    logic                mem_we;
    logic [STORE_AW-1:0] mem_waddr;
    logic [6:0]          mem_wdata;
    logic [STORE_AW-1:0] mem_raddr;

    logic [COL_W-1:0]  cur_col;
    logic [1:0]        mode_cur;
    logic              top_cur;
    logic              step_is_knob;
    logic [SUB_W-1:0]  sub_m2;
    logic [1:0]        kidx;
    logic [2:0]        knob_off;
    logic [SLOT_W-1:0] knob_slot;
    logic              last_step;
    out_item_t         res;

    assign cur_col      = {set_reg, col_cnt_reg};
    assign mode_cur     = mode_reg[cur_col];
    assign top_cur      = top_row[col_cnt_reg];
    assign sub_m2       = sub_cnt_reg - SUB_W'(2);
    assign step_is_knob = knobs_first_reg ? (sub_cnt_reg < SUB_W'(4))
                                          : (sub_cnt_reg >= SUB_W'(2));
    assign kidx         = (state_reg == B_START) ? cmd_reg.sel
                        : (knobs_first_reg ? sub_cnt_reg[1:0] : sub_m2[1:0]);
    assign knob_off     = (kidx == 2'd0 && top_cur) ? 3'd4 : {1'b0, kidx};
    assign knob_slot    = SLOT_W'({mode_cur, 2'b00}) + SLOT_W'(mode_cur) + SLOT_W'(knob_off);
    assign mem_raddr    = store_addr(cur_col, knob_slot);

    assign status.clearing = (state_reg == B_CLEAR);
    assign m_valid         = out_valid_reg;
    assign m_item          = out_item_reg;

    // result for the current step and where the sequence goes next
    always_comb begin
        res              = '0;
        last_step        = 1'b0;
        phase_next       = phase_reg;
        col_cnt_next     = col_cnt_reg;
        sub_cnt_next     = sub_cnt_reg + 1'b1;
        case (phase_reg)
            PH_SET_PRE, PH_SET_POST: begin
                res.midi_status = ST_SET;
                res.midi_data1  = CC_SET_BASE + 7'(sub_cnt_reg[1:0]);
                res.midi_data2  = (sub_cnt_reg[1:0] == set_reg) ? LED_ON : LED_OFF;
                if (sub_cnt_reg == SUB_W'(3)) begin
                    if (phase_reg == PH_SET_PRE) begin
                        phase_next   = PH_COLS;
                        sub_cnt_next = '0;
                        col_cnt_next = '0;
                    end else begin
                        last_step = 1'b1;
                    end
                end
            end
            PH_COLS: begin
                res.midi_status = ST_COL_BASE + 8'(col_cnt_reg);
                if (step_is_knob) begin
                    res.midi_data1 = KNOB_CC[kidx];
                    res.midi_data2 = rdata_reg;
                end else begin
                    res.midi_data1 = sub_cnt_reg[0] ? CC_DOWN : CC_UP;
                    res.midi_data2 = (sub_cnt_reg[0] ? mode_cur[1] : mode_cur[0])
                                   ? LED_OFF : LED_ON;
                end
                if (sub_cnt_reg == sub_last_reg) begin
                    sub_cnt_next = '0;
                    if (col_cnt_reg == col_last_reg) begin
                        if (set_post_reg) begin
                            phase_next = PH_SET_POST;
                        end else begin
                            last_step = 1'b1;
                        end
                    end else begin
                        col_cnt_next = col_cnt_reg + 1'b1;
                    end
                end
            end
            PH_EVENT: begin
                res.kind         = 1'b1;
                res.event_column = cur_col;
                res.event_slot   = slot_reg;
                res.event_value  = cmd_reg.value;
                last_step        = 1'b1;
            end
            default: last_step = 1'b1;
        endcase
        res.last = last_step;
    end

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        col_last_next    = col_last_reg;
        sub_last_next    = sub_last_reg;
        knobs_first_next = knobs_first_reg;
        set_post_next    = set_post_reg;
        set_next         = set_reg;
        mode_next        = mode_reg;
        slot_next        = slot_reg;
        clear_cnt_next   = clear_cnt_reg;
        out_valid_next   = (out_valid_reg && !m_ready);
        out_item_next    = out_item_reg;
        pop_ready        = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = clear_cnt_reg;
        mem_wdata        = '0;
        case (state_reg)
            B_CLEAR: begin
                mem_we         = 1'b1;
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == STORE_AW'(STORE_DEPTH - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    cmd_next   = pop_item;
                    state_next = B_START;
                end
            end
            B_START: begin
                state_next       = B_FETCH;
                col_last_next    = col_cnt_reg;
                sub_last_next    = SUB_W'(5);
                knobs_first_next = 1'b0;
                set_post_next    = 1'b0;
                case (cmd_reg.op)
                    OP_INIT: begin
                        set_next      = 2'd0;
                        mode_next     = '0;
                        col_last_next = SURF_W'(SURFACE_COLUMNS - 1);
                    end
                    OP_SET_SELECT: begin
                        set_next         = cmd_reg.sel;
                        col_last_next    = SURF_W'(SURFACE_COLUMNS - 1);
                        knobs_first_next = 1'b1;
                        set_post_next    = 1'b1;
                    end
                    OP_SET_LEDS: begin
                    end
                    OP_BUTTON: begin
                        if (cmd_reg.pressed) begin
                            mode_next[cur_col] = cmd_reg.sel[0] ? mode_cur + 1'b1
                                                                : mode_cur - 1'b1;
                        end else begin
                            sub_last_next = SUB_W'(1);
                        end
                    end
                    OP_KNOB: begin
                        mem_we    = 1'b1;
                        mem_waddr = store_addr(cur_col, knob_slot);
                        mem_wdata = cmd_reg.value;
                        slot_next = knob_slot;
                    end
                    OP_LOAD: begin
                        mem_we     = 1'b1;
                        mem_waddr  = store_addr(cmd_reg.load_col, cmd_reg.load_slot);
                        mem_wdata  = cmd_reg.value;
                        state_next = B_IDLE;
                    end
                    default: state_next = B_IDLE;
                endcase
            end
            B_FETCH: begin
                state_next = B_SHOW;
            end
            B_SHOW: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_item_next  = res;
                    state_next     = last_step ? B_IDLE : B_FETCH;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // sequence counters and phase, set at the start of each command and stepped with each result
    logic [SURF_W-1:0] seq_col_next;
    logic [SUB_W-1:0]  seq_sub_next;
    phase_t            seq_phase_next;

    always_comb begin
        seq_col_next   = col_cnt_reg;
        seq_sub_next   = sub_cnt_reg;
        seq_phase_next = phase_reg;
        case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    seq_col_next = pop_item.surf_col;
                end
            end
            B_START: begin
                seq_sub_next = '0;
                case (cmd_reg.op)
                    OP_INIT: begin
                        seq_phase_next = PH_SET_PRE;
                        seq_col_next   = '0;
                    end
                    OP_SET_SELECT: begin
                        seq_phase_next = PH_COLS;
                        seq_col_next   = '0;
                    end
                    OP_SET_LEDS: seq_phase_next = PH_SET_POST;
                    OP_BUTTON:   seq_phase_next = PH_COLS;
                    OP_KNOB:     seq_phase_next = PH_EVENT;
                    default:     seq_phase_next = phase_reg;
                endcase
            end
            B_SHOW: begin
                if (!out_valid_reg || m_ready) begin
                    seq_col_next   = col_cnt_next;
                    seq_sub_next   = sub_cnt_next;
                    seq_phase_next = phase_next;
                end
            end
            default: seq_phase_next = phase_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            clear_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            set_reg       <= '0;
            mode_reg      <= '0;
            phase_reg     <= PH_SET_PRE;
        end else begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            out_valid_reg <= out_valid_next;
            set_reg       <= set_next;
            mode_reg      <= mode_next;
            phase_reg     <= seq_phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        col_cnt_reg     <= seq_col_next;
        sub_cnt_reg     <= seq_sub_next;
        col_last_reg    <= col_last_next;
        sub_last_reg    <= sub_last_next;
        knobs_first_reg <= knobs_first_next;
        set_post_reg    <= set_post_next;
        slot_reg        <= slot_next;
        out_item_reg    <= out_item_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= store_mem[mem_raddr];
    end

endmodule

/* src/control_surface_bank_remapper_top.sv */
// Control surface bank remapper. Items from the surface are decoded into commands and
// held in a two-entry queue; a sequencer then works through them one at a time against
// a 640-entry knob store (32 columns by 20 slots, one read and one write port) and a
// single output register. Each result is a store read followed by an output load, and
// an item gives one result for a knob turn, six for a mode change, 52 for a set change
// or initialise and none for a store load. After reset the store is cleared entry by
// entry, during which s_ready stays low; the APB port can be written at any time.
module control_surface_bank_remapper_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  csbr_pkg::in_item_t                s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output csbr_pkg::out_item_t               m_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [csbr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [csbr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [csbr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import csbr_pkg::*;

    logic [7:0]   top_row_reg, top_row_next;
    back_status_t status;
    logic         push_valid, push_ready;
    cmd_t         push_item;
    logic         pop_valid, pop_ready;
    cmd_t         pop_item;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TOP_ROW) ? CFG_DATA_W'(top_row_reg) : '0;

    always_comb begin
        top_row_next = top_row_reg;
        if (psel && penable && pwrite && pready && paddr == REG_TOP_ROW) begin
            top_row_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_row_reg <= '0;
        end else begin
            top_row_reg <= top_row_next;
        end
    end

    csbr_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .status     (status),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    csbr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    csbr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .top_row   (top_row_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

/* src/csbr_checker.sv */
module csbr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input csbr_pkg::out_item_t m_item
);
    import csbr_pkg::*;

    // no result straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // a knob event is always the only result of its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind |-> m_item.last && m_item.midi_status == 8'd0 &&
        m_item.midi_data1 == 7'd0 && m_item.midi_data2 == 7'd0)
        else $error("bad knob event");

    // surface messages carry a set or column status and no event fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.kind |-> (m_item.midi_status == ST_SET ||
        m_item.midi_status[7:3] == ST_COL_BASE[7:3]) && m_item.event_column == '0 &&
        m_item.event_slot == '0 && m_item.event_value == 7'd0)
        else $error("bad surface message");

endmodule

bind control_surface_bank_remapper_top csbr_checker u_csbr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

/* sim/bank_remap_checker.sv */
module bank_remap_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  csbr_pkg::in_item_t              s_item,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  csbr_pkg::out_item_t             m_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [csbr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [csbr_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic [csbr_pkg::CFG_DATA_W-1:0] prdata,
    output int                              mismatches,
    output int                              pending,
    output int                              items_taken,
    output int                              results_seen
);
    import csbr_pkg::*;

    localparam int KNOBS_PER_MODE = 5;

    logic [7:0] top_row;
    logic [1:0] active_set;
    logic [1:0] col_mode [COLUMN_COUNT];
    logic [6:0] knob_mem [STORE_DEPTH];
    out_item_t  due_msgs [$];
    int         mismatch_count;
    int         item_count;
    int         result_count;

    assign mismatches   = mismatch_count;
    assign items_taken  = item_count;
    assign results_seen = result_count;

    task automatic report(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report($sformatf("result %0d %s got %0d expected %0d", result_count, name,
                             got, want));
        end
    endtask

    function automatic int mem_index(input logic [4:0] col, input logic [4:0] slot);
        return int'(col) * SLOTS_PER_COLUMN + int'(slot);
    endfunction

    task automatic push_msg(input logic kind, input logic [7:0] st, input logic [6:0] d1,
                            input logic [6:0] d2, input logic [4:0] col,
                            input logic [4:0] slot, input logic [6:0] val);
        out_item_t m;
        m.kind         = kind;
        m.midi_status  = st;
        m.midi_data1   = d1;
        m.midi_data2   = d2;
        m.event_column = col;
        m.event_slot   = slot;
        m.event_value  = val;
        m.last         = 1'b0;
        due_msgs.insert(due_msgs.size(), m);
    endtask

    task automatic show_set_leds();
        for (int i = 0; i < 4; i++) begin
            push_msg(1'b0, ST_SET, CC_SET_BASE + 7'(i),
                     (2'(i) == active_set) ? LED_ON : LED_OFF, '0, '0, '0);
        end
    endtask

    task automatic show_mode_leds(input logic [4:0] col);
        logic [1:0] m;
        logic [7:0] st;
        m  = col_mode[col];
        st = ST_COL_BASE + 8'(col[2:0]);
        push_msg(1'b0, st, CC_UP, m[0] ? LED_OFF : LED_ON, '0, '0, '0);
        push_msg(1'b0, st, CC_DOWN, (m > 2'd1) ? LED_OFF : LED_ON, '0, '0, '0);
    endtask

    task automatic show_knob_values(input logic [4:0] col);
        logic [7:0] st;
        logic [4:0] slot;
        st = ST_COL_BASE + 8'(col[2:0]);
        for (int i = 0; i < 4; i++) begin
            slot = 5'(col_mode[col]) * 5'(KNOBS_PER_MODE) + 5'(i);
            if (i == 0 && top_row[col[2:0]]) begin
                slot = slot + 5'd4;
            end
            push_msg(1'b0, st, KNOB_CC[i], knob_mem[mem_index(col, slot)], '0, '0, '0);
        end
    endtask

    task automatic remap_item(input in_item_t it);
        logic [4:0] col;
        logic [4:0] slot;
        int         first;
        first = due_msgs.size();
        case (it.action)
            ACT_INIT: begin
                foreach (col_mode[c]) col_mode[c] = 2'd0;
                active_set = 2'd0;
                show_set_leds();
                for (int i = 0; i < SURFACE_COLUMNS; i++) begin
                    show_mode_leds(5'(i));
                    show_knob_values(5'(i));
                end
            end
            ACT_LOAD: begin
                if (it.load_slot < SLOTS_PER_COLUMN) begin
                    knob_mem[mem_index(it.load_column, it.load_slot)] = it.data2;
                end
            end
            ACT_SURFACE: begin
                if (it.status_byte == ST_SET && it.data1 >= CC_SET_BASE &&
                    it.data1 <= CC_SET_LAST) begin
                    if (it.data2 != 7'd0) begin
                        active_set = 2'(it.data1 - CC_SET_BASE);
                        for (int i = 0; i < SURFACE_COLUMNS; i++) begin
                            col = {active_set, 3'(i)};
                            show_knob_values(col);
                            show_mode_leds(col);
                        end
                    end
                    show_set_leds();
                end
                if (it.status_byte >= ST_COL_BASE && it.status_byte <= ST_COL_LAST) begin
                    col = {active_set, it.status_byte[2:0]};
                    if (it.data1 == CC_UP || it.data1 == CC_DOWN) begin
                        if (it.data2 == 7'd0) begin
                            if (it.data1 == CC_UP) begin
                                col_mode[col] = col_mode[col] - 2'd1;
                            end else begin
                                col_mode[col] = col_mode[col] + 2'd1;
                            end
                        end
                        show_mode_leds(col);
                        if (it.data2 == 7'd0) begin
                            show_knob_values(col);
                        end
                    end
                    for (int i = 0; i < 4; i++) begin
                        if (it.data1 == KNOB_CC[i]) begin
                            slot = 5'(col_mode[col]) * 5'(KNOBS_PER_MODE) +
                                   ((i == 0 && top_row[col[2:0]]) ? 5'd4 : 5'(i));
                            push_msg(1'b1, '0, '0, '0, col, slot, it.data2);
                            knob_mem[mem_index(col, slot)] = it.data2;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (due_msgs.size() > first) begin
            due_msgs[due_msgs.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            top_row    = 8'h00;
            active_set = 2'd0;
            foreach (col_mode[c]) col_mode[c] = 2'd0;
            foreach (knob_mem[k]) knob_mem[k] = 7'd0;
            due_msgs.delete();
            mismatch_count = 0;
            item_count     = 0;
            result_count   = 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (due_msgs.size() == 0) begin
                    report($sformatf("result %0d arrived with nothing expected", result_count));
                end else begin
                    want = due_msgs.pop_front();
                    check_field("kind", 8'(m_item.kind), 8'(want.kind));
                    check_field("midi_status", m_item.midi_status, want.midi_status);
                    check_field("midi_data1", 8'(m_item.midi_data1), 8'(want.midi_data1));
                    check_field("midi_data2", 8'(m_item.midi_data2), 8'(want.midi_data2));
                    check_field("event_column", 8'(m_item.event_column),
                                8'(want.event_column));
                    check_field("event_slot", 8'(m_item.event_slot), 8'(want.event_slot));
                    check_field("event_value", 8'(m_item.event_value),
                                8'(want.event_value));
                    check_field("last", 8'(m_item.last), 8'(want.last));
                end
            end
            if (s_valid && s_ready) begin
                item_count++;
                remap_item(s_item);
            end
            if (psel && penable && pready && paddr == REG_TOP_ROW) begin
                if (pwrite) begin
                    top_row = pwdata[7:0];
                end else if (prdata[7:0] !== top_row) begin
                    report($sformatf("top row readback %0h expected %0h", prdata[7:0],
                                     top_row));
                end
            end
        end
        pending <= due_msgs.size();
    end

endmodule

/* sim/tb_control_surface_bank_remapper_top.sv */
module tb_control_surface_bank_remapper_top;

    import csbr_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES = 50;
    localparam int TAIL_CYCLES = 200;
    localparam int PHASE_ITEMS = 80;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int   mismatches;
    int   pending;
    int   items_taken;
    int   results_seen;
    int   send_idle_pct = 0;
    int   out_stall_pct = 0;
    int   top_row_writes = 0;
    logic hold_request = 1'b0;
    int   send_pct [5] = '{0, 55, 0, 20, 0};
    int   stall_pct [5] = '{0, 0, 55, 20, 0};

    always #4 aclk = ~aclk;

    control_surface_bank_remapper_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bank_remap_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .items_taken  (items_taken),
        .results_seen (results_seen)
    );

    function automatic logic [6:0] random_value();
        if ($urandom_range(7) == 0) begin
            return $urandom_range(1) ? 7'd127 : 7'd0;
        end
        return 7'($urandom);
    endfunction

    function automatic in_item_t surface_msg(input logic [7:0] st, input logic [6:0] d1,
                                             input logic [6:0] d2);
        in_item_t it;
        it.action      = ACT_SURFACE;
        it.status_byte = st;
        it.data1       = d1;
        it.data2       = d2;
        it.load_column = 5'($urandom);
        it.load_slot   = 5'($urandom);
        return it;
    endfunction

    function automatic in_item_t load_msg(input logic [4:0] col, input logic [4:0] slot,
                                          input logic [6:0] val);
        in_item_t it;
        it             = surface_msg(8'($urandom), 7'($urandom), val);
        it.action      = ACT_LOAD;
        it.load_column = col;
        it.load_slot   = slot;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        pick = $urandom_range(99);
        it   = surface_msg(ST_COL_BASE + 8'($urandom_range(7)), KNOB_CC[$urandom_range(3)],
                           random_value());
        if (pick < 25) begin
            it.data1 = $urandom_range(1) ? CC_UP : CC_DOWN;
            it.data2 = ($urandom_range(3) == 0) ? 7'($urandom_range(1, 127)) : 7'd0;
        end else if (pick < 35) begin
            it.status_byte = ST_SET;
            it.data1       = CC_SET_BASE + 7'($urandom_range(3));
            it.data2       = ($urandom_range(4) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
        end else if (pick < 50) begin
            it = load_msg(5'($urandom), ($urandom_range(9) == 0) ?
                          5'($urandom_range(20, 31)) : 5'($urandom_range(19)),
                          random_value());
        end else if (pick < 53) begin
            it.action = ACT_INIT;
        end else if (pick < 65) begin
            it.action      = 2'($urandom);
            it.status_byte = 8'($urandom);
            it.data1       = 7'($urandom);
        end
        return it;
    endfunction

    task automatic offer(input in_item_t it);
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_top_row(input logic [7:0] v);
        top_row_writes++;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TOP_ROW;
        pwdata  <= {24'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    initial begin
        in_item_t it;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        write_top_row(8'h5A);

        it        = surface_msg(8'($urandom), 7'($urandom), 7'($urandom));
        it.action = ACT_INIT;
        offer(it);
        offer(load_msg(5'd31, 5'd19, 7'd127));
        offer(load_msg(5'd0, 5'd0, 7'd1));
        offer(load_msg(5'd5, 5'd20, 7'd77));
        offer(load_msg(5'd31, 5'd31, 7'd3));
        offer(load_msg(5'd24, 5'd4, 7'd99));
        offer(surface_msg(ST_SET, CC_SET_LAST, 7'd127));
        offer(surface_msg(ST_SET, CC_SET_BASE, 7'd0));
        offer(surface_msg(ST_COL_BASE, CC_UP, 7'd0));
        offer(surface_msg(ST_COL_BASE, CC_DOWN, 7'd0));
        offer(surface_msg(ST_COL_LAST, CC_DOWN, 7'd0));
        offer(surface_msg(ST_COL_LAST, CC_UP, 7'd127));
        offer(surface_msg(ST_COL_BASE, KNOB_CC[0], 7'd0));
        offer(surface_msg(ST_COL_BASE + 8'd1, KNOB_CC[1], 7'd127));
        offer(surface_msg(ST_COL_BASE + 8'd2, KNOB_CC[2], 7'd64));
        offer(surface_msg(ST_COL_LAST, KNOB_CC[3], 7'd127));
        offer(surface_msg(ST_COL_LAST, KNOB_CC[0], 7'd1));
        offer(surface_msg(8'd255, 7'd127, 7'd127));
        offer(surface_msg(8'd0, 7'd0, 7'd0));
        offer(surface_msg(ST_SET, CC_SET_LAST + 7'd1, 7'd1));
        offer(surface_msg(ST_COL_LAST + 8'd1, KNOB_CC[0], 7'd5));
        offer(surface_msg(ST_COL_BASE - 8'd1, CC_UP, 7'd0));
        it        = surface_msg(ST_SET, CC_SET_BASE, 7'd127);
        it.action = ACT_UNUSED;
        offer(it);
        offer(surface_msg(ST_SET, CC_SET_BASE + 7'd1, 7'd1));
        it        = surface_msg(8'($urandom), 7'($urandom), 7'($urandom));
        it.action = ACT_INIT;
        offer(it);
        settle();

        for (int p = 0; p < 5; p++) begin
            if (p == 0) begin
                write_top_row(8'h00);
            end else if (p == 1) begin
                write_top_row(8'hFF);
            end else begin
                write_top_row(8'($urandom));
            end
            send_idle_pct = send_pct[p];
            out_stall_pct = stall_pct[p];
            if (p == 4) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                offer(random_item());
            end
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d items and %0d results over %0d top-row settings", items_taken,
                 results_seen, top_row_writes);
        $display("phases: no idling, sender gaps, receiver stalls, both, %0d-cycle hold",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("control_surface_bank_remapper_top test passed");
        end else begin
            $display("control_surface_bank_remapper_top test failed");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("control_surface_bank_remapper_top test failed");
        $finish;
    end

endmodule
